@@ src/dlsq_pkg.sv @@
// Shared types and defaults for the delta-list sleep queue.
package dlsq_pkg;

  // Default sizing
  localparam int unsigned DLSQ_MAX_SLEEPERS = 16;
  localparam int unsigned DLSQ_TIME_WIDTH   = 32;

  // Fixed field widths of the channel words
  localparam int unsigned THREAD_W  = 4;
  localparam int unsigned TIMEOUT_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WOKEN    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [THREAD_W-1:0]  thread_id;
    logic [TIMEOUT_W-1:0] timeout;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [THREAD_W-1:0] woken_id;
    logic                last;
  } out_word_t;

  // Requests from the sequencer to the free-slot list
  typedef struct packed {
    logic alloc;
    logic retire;
  } fl_cmd_t;

endpackage

@@ src/dlsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dlsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dlsq_free_list.sv @@
// Free-slot list: a stack of released slots in RAM plus a counter that hands out never-used slots in order.
module dlsq_free_list import dlsq_pkg::*; #(
  parameter int unsigned MAX_SLEEPERS = DLSQ_MAX_SLEEPERS,
  parameter int unsigned SW = $clog2(MAX_SLEEPERS),
  parameter int unsigned CW = $clog2(MAX_SLEEPERS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fl_cmd_t       cmd_i,
  input  logic [SW-1:0] release_slot_i,
  output logic [SW-1:0] alloc_slot_o
);

  logic [CW-1:0] stack_cnt_q, stack_cnt_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic          from_stack_q;
  logic [SW-1:0] fresh_slot_q;
  logic [CW-1:0] stack_top;
  logic          pop;
  logic [SW-1:0] stack_rdata;

  assign stack_top = stack_cnt_q - CW'(1);
  assign pop       = cmd_i.alloc && (stack_cnt_q != '0);

  // Count updates; alloc and release never coincide
  always_comb begin
    stack_cnt_d = stack_cnt_q;
    fresh_d     = fresh_q;
    if (pop) begin
      stack_cnt_d = stack_cnt_q - CW'(1);
    end else if (cmd_i.alloc) begin
      fresh_d = fresh_q + CW'(1);
    end
    if (cmd_i.retire) begin
      stack_cnt_d = stack_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_cnt_q  <= '0;
      fresh_q      <= '0;
      from_stack_q <= 1'b0;
    end else begin
      stack_cnt_q <= stack_cnt_d;
      fresh_q     <= fresh_d;
      if (cmd_i.alloc) begin
        from_stack_q <= pop;
      end
    end
  end

  // Next never-used slot, captured on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      fresh_slot_q <= fresh_q[SW-1:0];
    end
  end

  dlsq_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SLEEPERS),
    .AW    (SW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.retire),
    .waddr_i (stack_cnt_q[SW-1:0]),
    .wdata_i (release_slot_i),
    .re_i    (pop),
    .raddr_i (stack_top[SW-1:0]),
    .rdata_o (stack_rdata)
  );

  // Slot is valid the cycle after the request
  assign alloc_slot_o = from_stack_q ? stack_rdata : fresh_slot_q;

`ifndef ASSERT_OFF
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |-> (stack_cnt_q != '0) || (fresh_q < CW'(MAX_SLEEPERS)))
    else $error("slot allocated with no free slot");
  a_release_inuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.retire |-> (stack_cnt_q < fresh_q))
    else $error("slot released with no slot in use");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.alloc && cmd_i.retire))
    else $error("alloc and release in one cycle");
`endif

endmodule

@@ src/delta_list_sleep_queue.sv @@
// Delta-list sleep queue: sequencer, entry RAM and output register.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per
// operation: insert a thread with a timeout, one timer tick, or remove a
// thread. Output channel (out_valid_o / out_stall_i / out_data_o) returns
// the results, the final one of each operation marked by last.
// Entries live in one RAM (thread, delta, link) with one read per cycle;
// released slots go onto a stack in a second RAM.
// Insert walks the list one entry per RAM read to find its place, then
// writes the new entry and, when it has a predecessor, that predecessor's
// link. Remove walks until the thread is found or the list ends; when
// found it moves the delta onto the successor and relinks the predecessor
// or the head. A tick counts the head down and wakes threads one word
// per cycle while the output register is free. A full queue, empty
// remove, empty tick or opcode 3 answer without a walk. One operation is
// in flight at a time and the next word is taken only once the final
// result has gone into the output register.
// Reset empties the queue at once; RAM contents need no clearing.
// A stalled result waits in the output register; the next word is still
// taken and worked on, and only its result step waits for the register.
module delta_list_sleep_queue import dlsq_pkg::*; #(
  parameter int unsigned MAX_SLEEPERS = DLSQ_MAX_SLEEPERS,
  parameter int unsigned TIME_WIDTH   = DLSQ_TIME_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned SW = $clog2(MAX_SLEEPERS);
  localparam int unsigned CW = $clog2(MAX_SLEEPERS + 1);
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned EW = THREAD_W + TW + SW;

  typedef enum logic [3:0] {
    S_IDLE, S_IALLOC, S_IWALK, S_INEW, S_IAPPEND, S_IPREV,
    S_RWALK, S_RNEXT, S_RLINK, S_THEAD, S_TNEXT, S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [SW-1:0]       head_q, head_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       n_q, n_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [SW-1:0]       prev_q, prev_d;
  logic                have_prev_q, have_prev_d;
  logic [THREAD_W-1:0] prev_thread_q, prev_thread_d;
  logic [TW-1:0]       prev_delta_q, prev_delta_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [TW-1:0]       left_q, left_d;
  logic [THREAD_W-1:0] tid_q, tid_d;
  logic [SW-1:0]       nxt_q, nxt_d;
  logic                has_next_q, has_next_d;
  logic [TW-1:0]       cur_delta_q, cur_delta_d;
  out_word_t           res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_data_q, out_data_d;

  logic                ram_re, ram_we;
  logic [SW-1:0]       ram_raddr, ram_waddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;
  logic [THREAD_W-1:0] rd_thread;
  logic [TW-1:0]       rd_delta;
  logic [SW-1:0]       rd_link;
  logic [TW-1:0]       tick_delta;
  logic [TW-1:0]       in_left;
  logic [SW-1:0]       new_link;
  logic                out_free;
  logic                last_step;
  fl_cmd_t             fl_cmd;
  logic [SW-1:0]       fl_rel_slot;
  logic [SW-1:0]       fl_slot;

  // Entry word fields
  assign rd_thread = ram_rdata[EW-1 -: THREAD_W];
  assign rd_delta  = ram_rdata[SW +: TW];
  assign rd_link   = ram_rdata[SW-1:0];

  assign tick_delta = (rd_delta == '0) ? '0 : rd_delta - TW'(1);
  assign in_left    = (TW'(in_data_i.timeout) == '0) ? TW'(1) : TW'(in_data_i.timeout);
  assign new_link   = has_next_q ? nxt_q : '0;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_step  = (n_q + CW'(1)) == occ_q;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    occ_d         = occ_q;
    n_d           = n_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    have_prev_d   = have_prev_q;
    prev_thread_d = prev_thread_q;
    prev_delta_d  = prev_delta_q;
    slot_d        = slot_q;
    left_d        = left_q;
    tid_d         = tid_q;
    nxt_d         = nxt_q;
    has_next_d    = has_next_q;
    cur_delta_d   = cur_delta_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;
    ram_re        = 1'b0;
    ram_raddr     = head_q;
    ram_we        = 1'b0;
    ram_waddr     = cur_q;
    ram_wdata     = ram_rdata;
    fl_cmd        = '0;
    fl_rel_slot   = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tid_d       = in_data_i.thread_id;
          n_d         = '0;
          have_prev_d = 1'b0;
          cur_d       = head_q;
          res_d       = '{status: ST_OK, woken_id: '0, last: 1'b1};
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (occ_q == CW'(MAX_SLEEPERS)) begin
                res_d.status = ST_FULL;
                state_d      = S_EMIT;
              end else begin
                fl_cmd.alloc = 1'b1;
                left_d       = in_left;
                state_d      = S_IALLOC;
              end
            end
            OP_REMOVE: begin
              if (occ_q == '0) begin
                res_d.status = ST_NOTFOUND;
                state_d      = S_EMIT;
              end else begin
                ram_re  = 1'b1;
                state_d = S_RWALK;
              end
            end
            OP_TICK: begin
              if (occ_q == '0) begin
                state_d = S_EMIT;
              end else begin
                ram_re  = 1'b1;
                state_d = S_THEAD;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      // Slot from the free list is ready; walk from the head, or append if the list is empty
      S_IALLOC: begin
        slot_d = fl_slot;
        if (occ_q == '0) begin
          state_d = S_IAPPEND;
        end else begin
          ram_re  = 1'b1;
          state_d = S_IWALK;
        end
      end

      // Read data is entry cur_q
      S_IWALK: begin
        if (left_q < rd_delta) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          ram_wdata = {rd_thread, rd_delta - left_q, rd_link};
          state_d   = S_INEW;
        end else begin
          left_d        = left_q - rd_delta;
          prev_d        = cur_q;
          prev_thread_d = rd_thread;
          prev_delta_d  = rd_delta;
          have_prev_d   = 1'b1;
          n_d           = n_q + CW'(1);
          if (last_step) begin
            state_d = S_IAPPEND;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_link;
            cur_d     = rd_link;
          end
        end
      end

      // New entry in front of cur_q
      S_INEW: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = {tid_q, left_q, cur_q};
        occ_d     = occ_q + CW'(1);
        if (have_prev_q) begin
          state_d = S_IPREV;
        end else begin
          head_d  = slot_q;
          state_d = S_EMIT;
        end
      end

      // New entry at the tail
      S_IAPPEND: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = {tid_q, left_q, {SW{1'b0}}};
        occ_d     = occ_q + CW'(1);
        if (have_prev_q) begin
          state_d = S_IPREV;
        end else begin
          head_d  = slot_q;
          state_d = S_EMIT;
        end
      end

      S_IPREV: begin
        ram_we    = 1'b1;
        ram_waddr = prev_q;
        ram_wdata = {prev_thread_q, prev_delta_q, slot_q};
        state_d   = S_EMIT;
      end

      // Remove: look for the thread nearest the head
      S_RWALK: begin
        if (rd_thread == tid_q) begin
          cur_delta_d   = rd_delta;
          has_next_d    = !last_step;
          nxt_d         = rd_link;
          fl_cmd.retire = 1'b1;
          fl_rel_slot   = cur_q;
          if (last_step) begin
            state_d = S_RLINK;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_link;
            state_d   = S_RNEXT;
          end
        end else if (last_step) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_EMIT;
        end else begin
          prev_d        = cur_q;
          prev_thread_d = rd_thread;
          prev_delta_d  = rd_delta;
          have_prev_d   = 1'b1;
          n_d           = n_q + CW'(1);
          ram_re        = 1'b1;
          ram_raddr     = rd_link;
          cur_d         = rd_link;
        end
      end

      // Successor takes over the removed delta
      S_RNEXT: begin
        ram_we    = 1'b1;
        ram_waddr = nxt_q;
        ram_wdata = {rd_thread, rd_delta + cur_delta_q, rd_link};
        state_d   = S_RLINK;
      end

      S_RLINK: begin
        occ_d = occ_q - CW'(1);
        if (have_prev_q) begin
          ram_we    = 1'b1;
          ram_waddr = prev_q;
          ram_wdata = {prev_thread_q, prev_delta_q, new_link};
        end else begin
          head_d = new_link;
        end
        state_d = S_EMIT;
      end

      // Tick: count the head down, wake it if it reaches zero
      S_THEAD: begin
        if (tick_delta != '0) begin
          ram_we    = 1'b1;
          ram_waddr = head_q;
          ram_wdata = {rd_thread, tick_delta, rd_link};
          state_d   = S_EMIT;
        end else begin
          tid_d         = rd_thread;
          fl_cmd.retire = 1'b1;
          fl_rel_slot   = head_q;
          occ_d         = occ_q - CW'(1);
          if (occ_q > CW'(1)) begin
            head_d    = rd_link;
            ram_re    = 1'b1;
            ram_raddr = rd_link;
            state_d   = S_TNEXT;
          end else begin
            head_d  = '0;
            res_d   = '{status: ST_WOKEN, woken_id: rd_thread, last: 1'b1};
            state_d = S_EMIT;
          end
        end
      end

      // Pending woken thread in tid_q; read data is the new head
      S_TNEXT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status: ST_WOKEN, woken_id: tid_q, last: (rd_delta != '0)};
          if (rd_delta == '0) begin
            tid_d         = rd_thread;
            fl_cmd.retire = 1'b1;
            fl_rel_slot   = head_q;
            occ_d         = occ_q - CW'(1);
            if (occ_q > CW'(1)) begin
              head_d    = rd_link;
              ram_re    = 1'b1;
              ram_raddr = rd_link;
            end else begin
              head_d  = '0;
              res_d   = '{status: ST_WOKEN, woken_id: rd_thread, last: 1'b1};
              state_d = S_EMIT;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk registers and payload
  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    have_prev_q   <= have_prev_d;
    prev_thread_q <= prev_thread_d;
    prev_delta_q  <= prev_delta_d;
    slot_q        <= slot_d;
    left_q        <= left_d;
    tid_q         <= tid_d;
    nxt_q         <= nxt_d;
    has_next_q    <= has_next_d;
    cur_delta_q   <= cur_delta_d;
    res_q         <= res_d;
    out_data_q    <= out_data_d;
  end

  dlsq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SLEEPERS),
    .AW    (SW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dlsq_free_list #(
    .MAX_SLEEPERS (MAX_SLEEPERS),
    .SW           (SW),
    .CW           (CW)
  ) u_free_list (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (fl_cmd),
    .release_slot_i (fl_rel_slot),
    .alloc_slot_o   (fl_slot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(MAX_SLEEPERS))
    else $error("occupancy above capacity");
  a_walk_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IWALK || state_q == S_RWALK) |-> (n_q < occ_q))
    else $error("walk went past the end of the list");
  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_WOKEN) |-> out_data_o.last)
    else $error("non-wake result without last");
`endif

endmodule
